### rtl/cts_pkg.sv
// Shared token kind codes, scanner mode codes and character helpers for the token scanner.
`timescale 1ns / 1ps

package cts_pkg;

   // Token kind codes carried on the result channel.
   localparam logic [4:0] K_IDENT   = 5'd0;
   localparam logic [4:0] K_INT     = 5'd1;
   localparam logic [4:0] K_REAL    = 5'd2;
   localparam logic [4:0] K_STRING  = 5'd3;
   localparam logic [4:0] K_KWINT   = 5'd4;
   localparam logic [4:0] K_KWFLOAT = 5'd5;
   localparam logic [4:0] K_ADD     = 5'd6;
   localparam logic [4:0] K_MUL     = 5'd7;
   localparam logic [4:0] K_ASSIGN  = 5'd8;
   localparam logic [4:0] K_REL     = 5'd9;
   localparam logic [4:0] K_AND     = 5'd10;
   localparam logic [4:0] K_OR      = 5'd11;
   localparam logic [4:0] K_NOT     = 5'd12;
   localparam logic [4:0] K_EQUAL   = 5'd13;
   localparam logic [4:0] K_SEMI    = 5'd14;
   localparam logic [4:0] K_COMMA   = 5'd15;
   localparam logic [4:0] K_LPAR    = 5'd16;
   localparam logic [4:0] K_RPAR    = 5'd17;
   localparam logic [4:0] K_LBRACE  = 5'd18;
   localparam logic [4:0] K_RBRACE  = 5'd19;
   localparam logic [4:0] K_IF      = 5'd20;
   localparam logic [4:0] K_WHILE   = 5'd21;
   localparam logic [4:0] K_RETURN  = 5'd22;
   localparam logic [4:0] K_ELSE    = 5'd23;
   localparam logic [4:0] K_UNKNOWN = 5'd24;
   localparam logic [4:0] K_END     = 5'd25;

   // Scanner mode codes: which kind of token is still open.
   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_IDENT  = 4'd1;
   localparam logic [3:0] M_INT    = 4'd2;
   localparam logic [3:0] M_INTDOT = 4'd3;
   localparam logic [3:0] M_REAL   = 4'd4;
   localparam logic [3:0] M_STRING = 4'd5;
   localparam logic [3:0] M_EQ     = 4'd6;
   localparam logic [3:0] M_BANG   = 4'd7;
   localparam logic [3:0] M_REL    = 4'd8;
   localparam logic [3:0] M_AMP    = 4'd9;
   localparam logic [3:0] M_BAR    = 4'd10;

   // Double quote byte, which opens and closes a string.
   localparam logic [7:0] CH_QUOTE = 8'h22;

   // Output queue geometry.
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   function automatic logic is_letter(input logic [7:0] b);
      return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b inside {[8'h09:8'h0D], 8'h20});
   endfunction

   // Keyword lookup on the buffered first bytes of an identifier.
   // n is the identifier length and fits says the length is six or less.
   function automatic logic [4:0] ident_kind(input logic [5:0][7:0] kbytes,
                                             input logic [2:0] n,
                                             input logic fits);
      logic [4:0] kind;
      kind = K_IDENT;
      if (fits) begin
         if (n == 3'd2 && kbytes[0] == "i" && kbytes[1] == "f") begin
            kind = K_IF;
         end else if (n == 3'd5 && kbytes[0] == "w" && kbytes[1] == "h" &&
                      kbytes[2] == "i" && kbytes[3] == "l" && kbytes[4] == "e") begin
            kind = K_WHILE;
         end else if (n == 3'd6 && kbytes[0] == "r" && kbytes[1] == "e" &&
                      kbytes[2] == "t" && kbytes[3] == "u" && kbytes[4] == "r" &&
                      kbytes[5] == "n") begin
            kind = K_RETURN;
         end else if (n == 3'd4 && kbytes[0] == "e" && kbytes[1] == "l" &&
                      kbytes[2] == "s" && kbytes[3] == "e") begin
            kind = K_ELSE;
         end else if (n == 3'd3 && kbytes[0] == "i" && kbytes[1] == "n" &&
                      kbytes[2] == "t") begin
            kind = K_KWINT;
         end else if (n == 3'd5 && kbytes[0] == "f" && kbytes[1] == "l" &&
                      kbytes[2] == "o" && kbytes[3] == "a" && kbytes[4] == "t") begin
            kind = K_KWFLOAT;
         end
      end
      return kind;
   endfunction

endpackage

### rtl/c_like_token_scanner_unit.sv
// Top level of the token scanner: scan state, per-byte token decode and output queue.
//
// Usage: source text enters one beat per byte on the req_ channel (req_text_byte),
// or as an end beat with req_end_of_text high, which flushes any open token and
// then emits an end token with rsp_last_token set. Tokens leave on the rsp_ channel,
// one token per beat, carrying kind, start offset, length and first byte.
// Throughput: one input beat per cycle while req_ready is high. Each byte is
// decoded in the cycle it is accepted; the up to three tokens it completes are
// registered into an eight-entry output queue and leave from its head on rsp_.
// The queue drains one token per cycle while rsp_ready is high. req_ready is
// high while at least three queue entries are free, so a stalled receiver fills
// the queue and then holds off the sender; no token is lost. Sustained rate is
// set by the queue drain: one token per cycle while rsp_ready is high.
// Reset (synchronous, active high) empties the queue, closes any open token and
// sets the byte offset to zero. After an end beat the scan state returns to
// those reset values, so the next byte starts a new text at offset zero.
`timescale 1ns / 1ps

module c_like_token_scanner_unit
   import cts_pkg::*;
#(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_text_byte,
   input  logic                     req_end_of_text,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [4:0]               rsp_token_kind,
   output logic [POSITION_BITS-1:0] rsp_start_position,
   output logic [LENGTH_BITS-1:0]   rsp_token_length,
   output logic [7:0]               rsp_first_char,
   output logic                     rsp_last_token
);

   typedef struct packed {
      logic [4:0]               kind;
      logic [POSITION_BITS-1:0] pos;
      logic [LENGTH_BITS-1:0]   len;
      logic [7:0]               first;
      logic                     last;
   } token_type;

   localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0]   LEN_TWO = LENGTH_BITS'(2);
   localparam logic [LENGTH_BITS-1:0]   LEN_SIX = LENGTH_BITS'(6);
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [CNT_BITS-1:0]      FREE_LIMIT = CNT_BITS'(QUEUE_DEPTH - 3);

   // Scan state.
   logic [3:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0]   len_ff, len_in;
   logic [5:0][7:0]          kw_ff, kw_in;
   logic [7:0]               pc_ff, pc_in;

   // Output queue.
   token_type                queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]      head_ff, head_in;
   logic [PTR_BITS-1:0]      tail_ff, tail_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;

   // Candidate tokens of one byte, in stream order: closed by the byte,
   // flushed (two slots), and started by the byte or the end token.
   token_type                cand [4];
   logic [3:0]               cand_v;
   logic [PTR_BITS-1:0]      wr_idx [4];
   logic [1:0]               push_cnt;

   logic                     accept;
   logic                     pop;
   logic                     absorbed;
   logic                     flush;
   logic [7:0]               b;
   logic [LENGTH_BITS-1:0]   len_inc1;
   logic [LENGTH_BITS-1:0]   len_inc2;
   logic [4:0]               id_kind;

   assign accept    = req_valid & req_ready;
   assign pop       = rsp_valid & rsp_ready;
   assign req_ready = (count_ff <= FREE_LIMIT);
   assign b         = req_text_byte;

   // Saturating length increments and keyword lookup of the open identifier.
   assign len_inc1 = (len_ff == LEN_MAX) ? LEN_MAX : len_ff + LEN_ONE;
   assign len_inc2 = (len_ff >= LEN_MAX - LEN_ONE) ? LEN_MAX : len_ff + LEN_TWO;
   assign id_kind  = ident_kind(kw_ff, len_ff[2:0], len_ff <= LEN_SIX);

   // Byte decode: continue the open token, flush it, and start a new one.
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff + POS_ONE;
      start_in = start_ff;
      len_in   = len_ff;
      kw_in    = kw_ff;
      pc_in    = pc_ff;
      absorbed = 1'b0;
      flush    = 1'b0;
      cand_v   = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '{kind: K_UNKNOWN, pos: pos_ff, len: LEN_ONE, first: b, last: 1'b0};
      end

      // Continue the open token with this byte.
      if (req_end_of_text) begin
         flush = 1'b1;
      end else begin
         case (mode_ff)
            M_IDENT: begin
               if (is_letter(b) || is_digit(b)) begin
                  absorbed = 1'b1;
                  if (len_ff < LEN_SIX) begin
                     kw_in[len_ff[2:0]] = b;
                  end
                  len_in = len_inc1;
               end else begin
                  flush = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(b)) begin
                  absorbed = 1'b1;
                  len_in   = len_inc1;
               end else if (b == ".") begin
                  absorbed = 1'b1;
                  mode_in  = M_INTDOT;
               end else begin
                  flush = 1'b1;
               end
            end
            M_INTDOT: begin
               if (is_digit(b)) begin
                  absorbed = 1'b1;
                  len_in   = len_inc2;
                  mode_in  = M_REAL;
               end else begin
                  flush = 1'b1;
               end
            end
            M_REAL: begin
               if (is_digit(b)) begin
                  absorbed = 1'b1;
                  len_in   = len_inc1;
               end else begin
                  flush = 1'b1;
               end
            end
            M_STRING: begin
               absorbed = 1'b1;
               len_in   = len_inc1;
               if (b == CH_QUOTE) begin
                  cand_v[0] = 1'b1;
                  cand[0]   = '{kind: K_STRING, pos: start_ff, len: len_inc1,
                                first: pc_ff, last: 1'b0};
                  mode_in   = M_IDLE;
               end
            end
            M_EQ, M_BANG, M_REL: begin
               if (b == "=") begin
                  absorbed  = 1'b1;
                  cand_v[0] = 1'b1;
                  cand[0]   = '{kind: (mode_ff == M_REL) ? K_REL : K_EQUAL, pos: start_ff,
                                len: LEN_TWO, first: pc_ff, last: 1'b0};
                  mode_in   = M_IDLE;
               end else begin
                  flush = 1'b1;
               end
            end
            M_AMP, M_BAR: begin
               if (b == pc_ff) begin
                  absorbed  = 1'b1;
                  cand_v[0] = 1'b1;
                  cand[0]   = '{kind: (mode_ff == M_AMP) ? K_AND : K_OR, pos: start_ff,
                                len: LEN_TWO, first: pc_ff, last: 1'b0};
                  mode_in   = M_IDLE;
               end else begin
                  flush = 1'b1;
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase
      end

      // Emit the token left open when the byte does not extend it.
      if (flush) begin
         case (mode_ff)
            M_IDENT: begin
               cand_v[1] = 1'b1;
               cand[1]   = '{kind: id_kind, pos: start_ff, len: len_ff,
                             first: pc_ff, last: 1'b0};
            end
            M_INT, M_REAL, M_STRING: begin
               cand_v[1] = 1'b1;
               cand[1]   = '{kind: (mode_ff == M_INT) ? K_INT :
                                   (mode_ff == M_REAL) ? K_REAL : K_STRING,
                             pos: start_ff, len: len_ff, first: pc_ff, last: 1'b0};
            end
            M_INTDOT: begin
               cand_v[1] = 1'b1;
               cand[1]   = '{kind: K_INT, pos: start_ff, len: len_ff,
                             first: pc_ff, last: 1'b0};
               cand_v[2] = 1'b1;
               cand[2]   = '{kind: K_UNKNOWN, pos: pos_ff - POS_ONE, len: LEN_ONE,
                             first: ".", last: 1'b0};
            end
            M_EQ, M_BANG, M_REL, M_AMP, M_BAR: begin
               cand_v[1] = 1'b1;
               cand[1]   = '{kind: (mode_ff == M_EQ) ? K_ASSIGN :
                                   (mode_ff == M_BANG) ? K_NOT :
                                   (mode_ff == M_REL) ? K_REL : K_UNKNOWN,
                             pos: start_ff, len: LEN_ONE, first: pc_ff, last: 1'b0};
            end
            default: begin
               cand_v[1] = 1'b0;
            end
         endcase
         mode_in = M_IDLE;
      end

      // End of text emits the end token and returns to the reset state;
      // otherwise a byte not taken by the open token starts a new one.
      if (req_end_of_text) begin
         cand_v[3] = 1'b1;
         cand[3]   = '{kind: K_END, pos: pos_ff, len: '0, first: 8'h00, last: 1'b1};
         mode_in   = M_IDLE;
         pos_in    = '0;
         start_in  = '0;
         len_in    = '0;
         kw_in     = '0;
         pc_in     = 8'h00;
      end else if (!absorbed && !is_space(b)) begin
         if (is_letter(b)) begin
            mode_in  = M_IDENT;
            kw_in    = '0;
            kw_in[0] = b;
         end else if (is_digit(b)) begin
            mode_in = M_INT;
         end else begin
            case (b)
               CH_QUOTE: mode_in = M_STRING;
               "=":      mode_in = M_EQ;
               "!":      mode_in = M_BANG;
               "<", ">": mode_in = M_REL;
               "&":      mode_in = M_AMP;
               "|":      mode_in = M_BAR;
               "+", "-": begin cand_v[3] = 1'b1; cand[3].kind = K_ADD;    end
               "*", "/": begin cand_v[3] = 1'b1; cand[3].kind = K_MUL;    end
               ";":      begin cand_v[3] = 1'b1; cand[3].kind = K_SEMI;   end
               ",":      begin cand_v[3] = 1'b1; cand[3].kind = K_COMMA;  end
               "(":      begin cand_v[3] = 1'b1; cand[3].kind = K_LPAR;   end
               ")":      begin cand_v[3] = 1'b1; cand[3].kind = K_RPAR;   end
               "{":      begin cand_v[3] = 1'b1; cand[3].kind = K_LBRACE; end
               "}":      begin cand_v[3] = 1'b1; cand[3].kind = K_RBRACE; end
               default:  begin cand_v[3] = 1'b1; cand[3].kind = K_UNKNOWN; end
            endcase
         end
         // A token that stays open records where it began.
         if (!cand_v[3]) begin
            start_in = pos_ff;
            len_in   = LEN_ONE;
            pc_in    = b;
         end
      end
   end

   // Queue slots for the candidates: packed behind the tail in stream order.
   always_comb begin
      wr_idx[0] = tail_ff;
      wr_idx[1] = tail_ff + PTR_BITS'(cand_v[0]);
      wr_idx[2] = tail_ff + PTR_BITS'(cand_v[0]) + PTR_BITS'(cand_v[1]);
      wr_idx[3] = tail_ff + PTR_BITS'(cand_v[0]) + PTR_BITS'(cand_v[1])
                + PTR_BITS'(cand_v[2]);
      push_cnt  = accept ? 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]) + 2'(cand_v[3])
                         : 2'd0;
      tail_in   = tail_ff + PTR_BITS'(push_cnt);
      head_in   = head_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
   end

   // Control and scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         kw_ff    <= '0;
         pc_ff    <= 8'h00;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            kw_ff    <= kw_in;
            pc_ff    <= pc_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue entries hold payload only.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (accept && cand_v[i]) begin
            queue_ff[wr_idx[i]] <= cand[i];
         end
      end
   end

   // Head of the queue drives the result channel.
   assign rsp_valid          = (count_ff != '0);
   assign rsp_token_kind     = queue_ff[head_ff].kind;
   assign rsp_start_position = queue_ff[head_ff].pos;
   assign rsp_token_length   = queue_ff[head_ff].len;
   assign rsp_first_char     = queue_ff[head_ff].first;
   assign rsp_last_token     = queue_ff[head_ff].last;

endmodule

### rtl/cts_checker.sv
// Port-level checks for the token scanner and the bind that attaches them.
`timescale 1ns / 1ps

module cts_checker
   import cts_pkg::*;
#(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [7:0]               req_text_byte,
   input logic                     req_end_of_text,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [4:0]               rsp_token_kind,
   input logic [POSITION_BITS-1:0] rsp_start_position,
   input logic [LENGTH_BITS-1:0]   rsp_token_length,
   input logic [7:0]               rsp_first_char,
   input logic                     rsp_last_token
);

   // The queue is empty in the first cycle after reset is released.
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("token shown right after reset");

   // Only the end token closes a run, and only it.
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_token == (rsp_token_kind == K_END)))
      else $error("last flag does not match end token");

   // The end token carries no lexeme.
   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_token) |-> (rsp_token_length == '0 && rsp_first_char == 8'h00))
      else $error("end token with length or first byte");

   // A stalled token beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_start_position) && $stable(rsp_token_length) &&
         $stable(rsp_first_char) && $stable(rsp_last_token)))
      else $error("stalled token beat changed");

endmodule

bind c_like_token_scanner_unit cts_checker #(
   .POSITION_BITS(POSITION_BITS),
   .LENGTH_BITS(LENGTH_BITS)
) u_cts_checker (.*);
